>>> rtl/core/consensus_log_index_table_assert.svh
// Assertion macros used by the checker file of the log index table.
// Both forms expect clk_i and rst_ni to be visible where they are used.
`ifndef CONSENSUS_LOG_INDEX_TABLE_ASSERT_SVH
`define CONSENSUS_LOG_INDEX_TABLE_ASSERT_SVH

// Same-cycle implication.
`define CLIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("log index table: same-cycle check failed");

// Next-cycle implication.
`define CLIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("log index table: next-cycle check failed");

`endif

>>> rtl/core/clit_pkg.sv
package clit_pkg;

  localparam int unsigned LOG_DEPTH = 1024;
  localparam int unsigned MAX_BATCH = 64;
  localparam int unsigned MAX_READ  = 64;

  // Log slots are taken from the low index bits, so the depth is a power of two.
  localparam int unsigned LOG_AW  = $clog2(LOG_DEPTH);
  localparam int unsigned STG_AW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int unsigned CNT_MAX = (MAX_BATCH > MAX_READ) ? MAX_BATCH : MAX_READ;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_MATCH   = 3'd1,
    OP_BEGIN   = 3'd2,
    OP_ENTRY   = 3'd3,
    OP_READ    = 3'd4,
    OP_COMPACT = 3'd5,
    OP_SEARCH  = 3'd6,
    OP_STATUS  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_PREV_ABSENT  = 3'd1,
    ST_EXHAUSTED    = 3'd2,
    ST_NOT_CONTIG   = 3'd3,
    ST_CONFLICT     = 3'd4,
    ST_BAD_BOUNDARY = 3'd5,
    ST_FULL         = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] index_value;
    logic [31:0] term_value;
    logic [1:0]  entry_kind;
    logic [31:0] payload_tag;
    logic [6:0]  item_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] result_index;
    logic [31:0] result_term;
    logic [1:0]  result_kind;
    logic [31:0] result_payload;
    logic [31:0] first_held;
    logic [31:0] last_held;
    logic [10:0] held_count;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [31:0] term;
    logic [1:0]  kind;
    logic [31:0] payload;
  } log_ent_t;

  typedef struct packed {
    logic [31:0] index;
    logic [31:0] term;
    logic [1:0]  kind;
    logic [31:0] payload;
  } stg_ent_t;

  typedef enum logic [3:0] {
    CMD_NONE        = 4'd0,
    CMD_LATCH       = 4'd1,
    CMD_EXEC        = 4'd2,
    CMD_MATCH_FIN   = 4'd3,
    CMD_COMPACT_FIN = 4'd4,
    CMD_SEARCH      = 4'd5,
    CMD_READ        = 4'd6,
    CMD_PRE         = 4'd7,
    CMD_CHK         = 4'd8,
    CMD_CMP_A       = 4'd9,
    CMD_CMP_B       = 4'd10,
    CMD_DECIDE      = 4'd11,
    CMD_WR          = 4'd12
  } cmd_e;

  typedef struct packed {
    logic [2:0] op;
    logic       done;
    logic       more;
    logic       brk;
  } sts_t;

  function automatic logic [LOG_AW-1:0] slot_of(logic [31:0] idx);
    return idx[LOG_AW-1:0];
  endfunction

endpackage

>>> rtl/core/clit_ram.sv
module clit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/clit_ctrl.sv
module clit_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  clit_pkg::sts_t sts_i,
  output clit_pkg::cmd_e cmd_o,
  output logic          busy_o
);
  import clit_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_EXEC    = 12'b0000_0000_0010,
    S_MATCH   = 12'b0000_0000_0100,
    S_COMPACT = 12'b0000_0000_1000,
    S_SEARCH  = 12'b0000_0001_0000,
    S_READ    = 12'b0000_0010_0000,
    S_PRE     = 12'b0000_0100_0000,
    S_CHK     = 12'b0000_1000_0000,
    S_CMP_A   = 12'b0001_0000_0000,
    S_CMP_B   = 12'b0010_0000_0000,
    S_DECIDE  = 12'b0100_0000_0000,
    S_WR      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_LATCH;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o = CMD_EXEC;
        if (sts_i.done) begin
          state_d = S_IDLE;
        end else begin
          case (op_e'(sts_i.op))
            OP_MATCH:           state_d = S_MATCH;
            OP_COMPACT:         state_d = S_COMPACT;
            OP_SEARCH:          state_d = S_SEARCH;
            OP_READ:            state_d = S_READ;
            OP_BEGIN, OP_ENTRY: state_d = S_PRE;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_MATCH: begin
        cmd_o   = CMD_MATCH_FIN;
        state_d = S_IDLE;
      end
      S_COMPACT: begin
        cmd_o   = CMD_COMPACT_FIN;
        state_d = S_IDLE;
      end
      S_SEARCH: begin
        cmd_o = CMD_SEARCH;
        if (sts_i.done) state_d = S_IDLE;
      end
      S_READ: begin
        cmd_o = CMD_READ;
        if (sts_i.done) state_d = S_IDLE;
      end
      S_PRE: begin
        cmd_o   = CMD_PRE;
        state_d = sts_i.done ? S_IDLE : S_CHK;
      end
      S_CHK: begin
        cmd_o = CMD_CHK;
        if (sts_i.done) begin
          state_d = S_IDLE;
        end else if (!sts_i.more) begin
          state_d = S_CMP_A;
        end
      end
      S_CMP_A: begin
        cmd_o   = CMD_CMP_A;
        state_d = sts_i.brk ? S_DECIDE : S_CMP_B;
      end
      S_CMP_B: begin
        cmd_o = CMD_CMP_B;
        if (sts_i.done) begin
          state_d = S_IDLE;
        end else if (sts_i.more) begin
          state_d = S_CMP_A;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o   = CMD_DECIDE;
        state_d = sts_i.done ? S_IDLE : S_WR;
      end
      S_WR: begin
        cmd_o = CMD_WR;
        if (sts_i.done) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/core/clit_dp.sv
module clit_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clit_pkg::in_t  in_i,
  input  clit_pkg::cmd_e cmd_i,
  output clit_pkg::sts_t sts_o,
  output logic           strobe_o,
  output clit_pkg::out_t res_o
);
  import clit_pkg::*;

  in_t              in_q, in_d;
  logic [31:0]      bidx_q, bidx_d, bterm_q, bterm_d, tail_q, tail_d;
  logic [31:0]      prev_q, prev_d, walk_q, walk_d;
  logic             act_q, act_d, brk_q, brk_d;
  logic [CNT_W-1:0] len_q, len_d, got_q, got_d, k_q, k_d, n_q, n_d;
  stg_ent_t         stg_q, stg_d;

  logic             strobe_q, strobe_d;
  logic [2:0]       rs_status_q, rs_status_d;
  logic             rs_found_q, rs_found_d, rs_last_q, rs_last_d;
  logic [31:0]      rs_index_q, rs_index_d, rs_term_q, rs_term_d, rs_pay_q, rs_pay_d;
  logic [1:0]       rs_kind_q, rs_kind_d;

  logic              log_we;
  logic [LOG_AW-1:0] log_waddr, log_raddr;
  log_ent_t          log_wdata, log_rd;
  logic              stg_we;
  stg_ent_t          stg_wdata, stg_rd;

  logic        held_in, held_prev;
  logic [31:0] cnt32, capped32, term_sel, new_tail, batch_last;
  logic [32:0] avail33, nsel33;

  clit_ram #(.WIDTH($bits(log_ent_t)), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (log_waddr),
    .wdata_i (log_wdata),
    .raddr_i (log_raddr),
    .rdata_o (log_rd)
  );

  clit_ram #(.WIDTH($bits(stg_ent_t)), .DEPTH(MAX_BATCH)) u_stg_ram (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (got_q[STG_AW-1:0]),
    .wdata_i (stg_wdata),
    .raddr_i (k_d[STG_AW-1:0]),
    .rdata_o (stg_rd)
  );

  assign held_in    = (in_q.index_value >= bidx_q) && (in_q.index_value <= tail_q);
  assign held_prev  = (prev_q >= bidx_q) && (prev_q <= tail_q);
  assign cnt32      = 32'(in_q.item_count);
  assign capped32   = (cnt32 > 32'(MAX_READ)) ? 32'(MAX_READ) : cnt32;
  assign avail33    = {1'b0, tail_q} - {1'b0, in_q.index_value} + 33'd1;
  assign nsel33     = ({1'b0, capped32} > avail33) ? avail33 : {1'b0, capped32};
  assign term_sel   = (walk_q == bidx_q) ? bterm_q : log_rd.term;
  assign batch_last = prev_q + 32'(len_q);
  assign new_tail   = brk_q ? batch_last : tail_q;
  assign stg_wdata  = '{index: in_q.index_value, term: in_q.term_value,
                        kind: in_q.entry_kind, payload: in_q.payload_tag};

  always_comb begin
    in_d      = in_q;
    bidx_d    = bidx_q;
    bterm_d   = bterm_q;
    tail_d    = tail_q;
    prev_d    = prev_q;
    walk_d    = walk_q;
    act_d     = act_q;
    brk_d     = brk_q;
    len_d     = len_q;
    got_d     = got_q;
    k_d       = k_q;
    n_d       = n_q;
    stg_d     = stg_q;
    strobe_d  = 1'b0;
    rs_status_d = ST_OK;
    rs_found_d  = 1'b0;
    rs_index_d  = '0;
    rs_term_d   = '0;
    rs_kind_d   = '0;
    rs_pay_d    = '0;
    rs_last_d   = 1'b0;
    sts_o       = '{op: in_q.opcode, done: 1'b0, more: 1'b0, brk: 1'b0};
    log_we      = 1'b0;
    log_waddr   = slot_of(tail_q + 32'd1);
    log_wdata   = '{term: in_q.term_value, kind: in_q.entry_kind,
                    payload: in_q.payload_tag};
    stg_we      = 1'b0;

    case (cmd_i)
      CMD_LATCH: begin
        in_d = in_i;
      end
      CMD_EXEC: begin
        case (op_e'(in_q.opcode))
          OP_APPEND: begin
            sts_o.done = 1'b1;
            strobe_d   = 1'b1;
            if ({1'b0, tail_q - bidx_q} >= 33'(LOG_DEPTH)) begin
              rs_status_d = ST_FULL;
            end else if (tail_q == '1) begin
              rs_status_d = ST_EXHAUSTED;
            end else begin
              log_we     = 1'b1;
              tail_d     = tail_q + 32'd1;
              rs_index_d = tail_q + 32'd1;
            end
          end
          OP_MATCH, OP_COMPACT: begin
            if (!held_in) begin
              sts_o.done  = 1'b1;
              strobe_d    = 1'b1;
              rs_status_d = (op_e'(in_q.opcode) == OP_MATCH) ? ST_PREV_ABSENT
                                                             : ST_BAD_BOUNDARY;
            end else begin
              walk_d = in_q.index_value;
            end
          end
          OP_BEGIN: begin
            act_d = 1'b0;
            if (cnt32 > 32'(MAX_BATCH)) begin
              sts_o.done  = 1'b1;
              strobe_d    = 1'b1;
              rs_status_d = ST_NOT_CONTIG;
            end else begin
              prev_d = in_q.index_value;
              len_d  = CNT_W'(cnt32);
              got_d  = '0;
              if (cnt32 != '0) begin
                act_d      = 1'b1;
                sts_o.done = 1'b1;
              end
            end
          end
          OP_ENTRY: begin
            if (!act_q || got_q >= len_q || got_q >= CNT_W'(MAX_BATCH)) begin
              act_d       = 1'b0;
              sts_o.done  = 1'b1;
              strobe_d    = 1'b1;
              rs_status_d = ST_NOT_CONTIG;
            end else begin
              stg_we = 1'b1;
              got_d  = got_q + 1'b1;
              if (got_q + 1'b1 < len_q) sts_o.done = 1'b1;
            end
          end
          OP_READ: begin
            if (!held_in) begin
              sts_o.done  = 1'b1;
              strobe_d    = 1'b1;
              rs_status_d = ST_PREV_ABSENT;
              rs_last_d   = 1'b1;
            end else if (cnt32 == '0) begin
              sts_o.done = 1'b1;
            end else begin
              n_d    = CNT_W'(nsel33);
              k_d    = '0;
              walk_d = in_q.index_value;
            end
          end
          OP_SEARCH: begin
            walk_d = bidx_q;
          end
          OP_STATUS: begin
            sts_o.done = 1'b1;
            strobe_d   = 1'b1;
          end
          default: begin
            sts_o.done = 1'b1;
          end
        endcase
      end
      CMD_MATCH_FIN: begin
        strobe_d   = 1'b1;
        rs_found_d = (term_sel == in_q.term_value);
        rs_index_d = walk_q;
        rs_term_d  = term_sel;
      end
      CMD_COMPACT_FIN: begin
        strobe_d = 1'b1;
        if (term_sel != in_q.term_value ||
            (walk_q == '0 && in_q.term_value != '0) ||
            (walk_q != '0 && in_q.term_value == '0)) begin
          rs_status_d = ST_BAD_BOUNDARY;
        end else begin
          bidx_d  = walk_q;
          bterm_d = in_q.term_value;
        end
      end
      CMD_SEARCH: begin
        if (term_sel == in_q.term_value) begin
          sts_o.done = 1'b1;
          strobe_d   = 1'b1;
          rs_found_d = 1'b1;
          rs_index_d = walk_q;
          rs_term_d  = term_sel;
        end else if (walk_q == tail_q) begin
          sts_o.done = 1'b1;
          strobe_d   = 1'b1;
        end else begin
          walk_d = walk_q + 32'd1;
        end
      end
      CMD_READ: begin
        // The boundary reads as a no-op entry with a zero payload tag.
        strobe_d   = 1'b1;
        rs_found_d = 1'b1;
        rs_index_d = walk_q;
        rs_term_d  = term_sel;
        rs_kind_d  = (walk_q == bidx_q) ? 2'd0 : log_rd.kind;
        rs_pay_d   = (walk_q == bidx_q) ? 32'd0 : log_rd.payload;
        if (k_q + 1'b1 < n_q) begin
          k_d    = k_q + 1'b1;
          walk_d = walk_q + 32'd1;
        end else begin
          rs_last_d  = 1'b1;
          sts_o.done = 1'b1;
        end
      end
      CMD_PRE: begin
        act_d  = 1'b0;
        brk_d  = 1'b0;
        k_d    = '0;
        walk_d = prev_q + 32'd1;
        if (!held_prev) begin
          sts_o.done  = 1'b1;
          strobe_d    = 1'b1;
          rs_status_d = ST_PREV_ABSENT;
        end else if (len_q == '0) begin
          sts_o.done = 1'b1;
          strobe_d   = 1'b1;
        end else if (prev_q == '1) begin
          sts_o.done  = 1'b1;
          strobe_d    = 1'b1;
          rs_status_d = ST_EXHAUSTED;
        end
      end
      CMD_CHK: begin
        if (stg_rd.index != walk_q || stg_rd.index == '0 || stg_rd.term == '0) begin
          sts_o.done  = 1'b1;
          strobe_d    = 1'b1;
          rs_status_d = ST_NOT_CONTIG;
        end else if (k_q + 1'b1 < len_q) begin
          sts_o.more = 1'b1;
          k_d        = k_q + 1'b1;
          walk_d     = walk_q + 32'd1;
        end else begin
          k_d = '0;
        end
      end
      CMD_CMP_A: begin
        stg_d = stg_rd;
        if (stg_rd.index > tail_q) begin
          brk_d     = 1'b1;
          sts_o.brk = 1'b1;
        end
      end
      CMD_CMP_B: begin
        if (log_rd.term != stg_q.term) begin
          brk_d     = 1'b1;
          sts_o.brk = 1'b1;
        end else if (log_rd.kind != stg_q.kind || log_rd.payload != stg_q.payload) begin
          sts_o.done  = 1'b1;
          strobe_d    = 1'b1;
          rs_status_d = ST_CONFLICT;
        end else if (k_q + 1'b1 < len_q) begin
          sts_o.more = 1'b1;
          k_d        = k_q + 1'b1;
        end
      end
      CMD_DECIDE: begin
        if ({1'b0, new_tail - bidx_q} > 33'(LOG_DEPTH)) begin
          sts_o.done  = 1'b1;
          strobe_d    = 1'b1;
          rs_status_d = ST_FULL;
        end else if (!brk_q) begin
          sts_o.done = 1'b1;
          strobe_d   = 1'b1;
          rs_index_d = batch_last;
        end
      end
      CMD_WR: begin
        log_we    = 1'b1;
        log_waddr = slot_of(stg_rd.index);
        log_wdata = '{term: stg_rd.term, kind: stg_rd.kind, payload: stg_rd.payload};
        if (k_q + 1'b1 < len_q) begin
          k_d = k_q + 1'b1;
        end else begin
          tail_d     = batch_last;
          sts_o.done = 1'b1;
          strobe_d   = 1'b1;
          rs_index_d = batch_last;
        end
      end
      default: begin
      end
    endcase

    // Every step reads the log at the walking index, except the first compare
    // step (CMD_CMP_A), which reads the slot named by the staged entry.
    if (cmd_i == CMD_CMP_A) begin
      log_raddr = slot_of(stg_rd.index);
    end else begin
      log_raddr = slot_of(walk_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidx_q   <= '0;
      bterm_q  <= '0;
      tail_q   <= '0;
      act_q    <= 1'b0;
      brk_q    <= 1'b0;
      len_q    <= '0;
      got_q    <= '0;
      k_q      <= '0;
      n_q      <= '0;
      prev_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      bidx_q   <= bidx_d;
      bterm_q  <= bterm_d;
      tail_q   <= tail_d;
      act_q    <= act_d;
      brk_q    <= brk_d;
      len_q    <= len_d;
      got_q    <= got_d;
      k_q      <= k_d;
      n_q      <= n_d;
      prev_q   <= prev_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    walk_q      <= walk_d;
    stg_q       <= stg_d;
    rs_status_q <= rs_status_d;
    rs_found_q  <= rs_found_d;
    rs_index_q  <= rs_index_d;
    rs_term_q   <= rs_term_d;
    rs_kind_q   <= rs_kind_d;
    rs_pay_q    <= rs_pay_d;
    rs_last_q   <= rs_last_d;
  end

  assign strobe_o = strobe_q;

  always_comb begin
    res_o.status         = rs_status_q;
    res_o.found          = rs_found_q;
    res_o.result_index   = rs_index_q;
    res_o.result_term    = rs_term_q;
    res_o.result_kind    = rs_kind_q;
    res_o.result_payload = rs_pay_q;
    res_o.first_held     = bidx_q;
    res_o.last_held      = tail_q;
    res_o.held_count     = 11'(tail_q - bidx_q);
    res_o.last_of_run    = rs_last_q;
  end

endmodule

>>> rtl/core/consensus_log_index_table.sv
// Channel   Direction  Handshake                      Payload
// command   in         start high, busy low           in_i  (clit_pkg::in_t)
// result    out        strobe_o high for one cycle    res_o (clit_pkg::out_t)
//
// Append, status and out-of-range errors give their result from the execute
// step; match and compact add a finishing step. A read run gives one result per
// cycle after a lead-in. Term search walks the entries one at a time.
// A batch commit makes a contiguity pass, a term compare pass (two steps per
// entry) and a write pass over the staged entries, one entry at a time, all set
// by the single read port of the log and staging memories.
// Reset is asynchronous and active low; the memories are not cleared.
// Results cannot be held off; busy stays high until the item is finished.
module consensus_log_index_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  clit_pkg::in_t  in_i,
  output logic           busy,
  output logic           strobe_o,
  output clit_pkg::out_t res_o
);
  import clit_pkg::*;

  cmd_e cmd;
  sts_t sts;

  clit_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  clit_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

endmodule

>>> rtl/core/clit_checker.sv
`include "consensus_log_index_table_assert.svh"

module clit_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           strobe_o,
  input clit_pkg::out_t res_o
);
  import clit_pkg::*;

  // A transfer always takes the block out of idle.
  `CLIT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // An idle block with no transfer produces nothing in the next cycle.
  `CLIT_ASSERT_NEXT(a_idle_quiet, !busy && !start, !strobe_o)

  // An error result never reports a hit.
  `CLIT_ASSERT_NOW(a_err_no_found, strobe_o && res_o.status != ST_OK, !res_o.found)

  // Held count follows the boundary and the tail.
  `CLIT_ASSERT_NOW(a_held_count, strobe_o,
                   res_o.held_count == 11'(res_o.last_held - res_o.first_held))

  // The end of a read run is either a read entry or an absent start.
  `CLIT_ASSERT_NOW(a_run_end, strobe_o && res_o.last_of_run,
                   res_o.found || res_o.status == ST_PREV_ABSENT)

endmodule

bind consensus_log_index_table clit_checker u_clit_checker (.*);
